@@ design/mhpq_pkg.sv @@
// Package with the sizes, codes and request/response types of the max-heap queue.
package mhpq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W      = ADDR_W + 1;
    localparam int KEY_W      = 32;
    localparam int FILL_W     = 7;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [31:0] key_in;
    } t_req;

    typedef struct packed {
        logic signed [31:0] max_out;
        logic [FILL_W-1:0]  fill_level;
        t_status            status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_RM_TOP,
        S_RM_MOVED,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DN_CMP
    } t_state;

endpackage

@@ design/mhpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/max_heap_priority_queue_core.sv @@
// Binary max-heap priority queue: sequencer, shared key comparator and heap RAM.
// A refused request never raises busy; an insert reads and compares one parent per level
// climbed; a remove reads up to two children per level descended (on the single RAM read
// port, one compare each). The response strobe is raised once busy is low again.
// Reset is synchronous and active low and empties the heap; the receiver cannot stall.
module max_heap_priority_queue_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mhpq_pkg::t_req i_req,
    output logic          o_done,
    output mhpq_pkg::t_rsp o_rsp
);
    import mhpq_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    t_rsp             r_rsp, n_rsp;
    logic             r_rm, n_rm;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_child, n_child;
    logic signed [KEY_W-1:0] r_top, n_top;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_cidx, n_cidx;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;
    logic signed [KEY_W-1:0] rd_key;

    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    logic             cmp_gt;
    logic [IDX_W-1:0] parent_idx;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
    logic [IDX_W-1:0] cnt_ext;

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key     = $signed(ram_rdata);
    assign parent_idx = (r_idx - IDX_W'(1)) >> 1;
    assign left_idx   = {r_idx[IDX_W-2:0], 1'b1};
    assign right_idx  = r_cidx + IDX_W'(1);
    assign cnt_ext    = IDX_W'(r_cnt);
    assign cmp_gt     = cmp_a > cmp_b;

    // The single comparator is shared by sift-up, child selection and sift-down.
    always_comb begin
        unique case (r_state)
            S_UP_CMP: begin
                cmp_a = r_key;
                cmp_b = rd_key;
            end
            S_DN_R: begin
                cmp_a = rd_key;
                cmp_b = r_child;
            end
            default: begin
                cmp_a = r_key;
                cmp_b = r_child;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp   <= n_rsp;
        r_rm    <= n_rm;
        r_key   <= n_key;
        r_child <= n_child;
        r_top   <= n_top;
        r_idx   <= n_idx;
        r_cidx  <= n_cidx;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        n_rm      = r_rm;
        n_key     = r_key;
        n_child   = r_child;
        n_top     = r_top;
        n_idx     = r_idx;
        n_cidx    = r_cidx;
        ram_we    = 1'b0;
        ram_waddr = r_idx[ADDR_W-1:0];
        ram_wdata = r_key;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rsp.max_out    = '0;
                    n_rsp.fill_level = FILL_W'(r_cnt);
                    if (i_req.req_type == REQ_INSERT) begin
                        if (r_cnt == CNT_W'(HEAP_DEPTH)) begin
                            n_rsp.status = STAT_FULL;
                            n_done       = 1'b1;
                        end else begin
                            n_rm    = 1'b0;
                            n_key   = i_req.key_in;
                            n_idx   = cnt_ext;
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_state = S_UP;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_rsp.status = STAT_EMPTY;
                            n_done       = 1'b1;
                        end else begin
                            // Root read is issued now; the last entry is read next.
                            n_rm      = 1'b1;
                            n_cnt     = r_cnt - CNT_W'(1);
                            ram_raddr = '0;
                            n_state   = S_RM_TOP;
                        end
                    end
                end
            end
            S_UP: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    ram_raddr = parent_idx[ADDR_W-1:0];
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = ram_rdata;
                    n_idx     = parent_idx;
                    n_state   = S_UP;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_RM_TOP: begin
                n_top     = rd_key;
                ram_raddr = r_cnt[ADDR_W-1:0];
                n_state   = S_RM_MOVED;
            end
            S_RM_MOVED: begin
                n_key   = rd_key;
                n_idx   = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (left_idx < cnt_ext) begin
                    ram_raddr = left_idx[ADDR_W-1:0];
                    n_cidx    = left_idx;
                    n_state   = S_DN_L;
                end else begin
                    // Removing the last key leaves nothing to place.
                    ram_we  = (r_cnt != '0);
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_DN_L: begin
                n_child = rd_key;
                if (right_idx < cnt_ext) begin
                    ram_raddr = right_idx[ADDR_W-1:0];
                    n_state   = S_DN_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_R: begin
                if (cmp_gt) begin
                    n_child = rd_key;
                    n_cidx  = right_idx;
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (cmp_gt) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    ram_wdata = r_child;
                    n_idx     = r_cidx;
                    n_state   = S_DN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_done && r_state != S_IDLE) begin
            n_rsp.max_out    = r_rm ? r_top : '0;
            n_rsp.fill_level = FILL_W'(r_cnt);
            n_rsp.status     = STAT_OK;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // An insert into a full heap is refused in the very next cycle.
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == REQ_INSERT && r_cnt == CNT_W'(HEAP_DEPTH))
        |=> (o_done && o_rsp.status == STAT_FULL))
        else $error("insert into full heap not refused");

    // A refused request leaves the entry count as it was.
    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != STAT_OK) |-> (r_cnt == $past(r_cnt)))
        else $error("refused request changed the entry count");

    // The heap is only ever written below the current entry count.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_idx < cnt_ext))
        else $error("heap write beyond entry count");

endmodule

@@ verif/max_heap_priority_queue_core_tb.sv @@
// Self-checking testbench for the max-heap priority queue core.
`timescale 1ns / 1ps

module max_heap_priority_queue_core_tb;
    import mhpq_pkg::*;

    localparam int MAX_PRINTS = 40;

    // Keeps a private copy of the heap and the responses it predicts.
    class heap_scoreboard;
        logic signed [KEY_W-1:0] keys[HEAP_DEPTH];
        int key_count;
        t_rsp pending_rsps[$];
        int mismatches;

        function new();
            key_count = 0;
            mismatches = 0;
        endfunction

        function int pending_count();
            return pending_rsps.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTS) begin
                $display("%0t mismatch: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        // Applies one accepted request to the heap copy and queues its response.
        function void note_request(t_req rq);
            t_rsp rsp;
            int idx;
            int child;
            int last;
            bit settled;
            logic signed [KEY_W-1:0] moved;
            logic signed [KEY_W-1:0] tmp;
            rsp = '0;
            rsp.status = STAT_OK;
            if (rq.req_type == REQ_INSERT) begin
                if (key_count >= HEAP_DEPTH) begin
                    rsp.status = STAT_FULL;
                end else begin
                    idx = key_count;
                    keys[idx] = rq.key_in;
                    key_count++;
                    // Climb only while strictly greater than the parent.
                    while (idx > 0 && keys[idx] > keys[(idx - 1) / 2]) begin
                        tmp = keys[idx];
                        keys[idx] = keys[(idx - 1) / 2];
                        keys[(idx - 1) / 2] = tmp;
                        idx = (idx - 1) / 2;
                    end
                end
            end else if (key_count == 0) begin
                rsp.status = STAT_EMPTY;
            end else begin
                rsp.max_out = keys[0];
                last = key_count - 1;
                moved = keys[last];
                key_count = last;
                idx = 0;
                settled = 1'b0;
                // The moved key passes a child equal to it; it stops only when greater.
                while (!settled && 2 * idx + 1 < last) begin
                    child = 2 * idx + 1;
                    if (child + 1 < last && keys[child + 1] > keys[child]) begin
                        child++;
                    end
                    if (moved > keys[child]) begin
                        settled = 1'b1;
                    end else begin
                        keys[idx] = keys[child];
                        idx = child;
                    end
                end
                if (last > 0) begin
                    keys[idx] = moved;
                end
            end
            rsp.fill_level = FILL_W'(key_count);
            pending_rsps.push_back(rsp);
        endfunction

        task check_response(t_rsp got);
            t_rsp want;
            if (pending_rsps.size() == 0) begin
                report_mismatch($sformatf("response with no request outstanding (max %0d)",
                    got.max_out));
            end else begin
                want = pending_rsps.pop_front();
                if (got.max_out !== want.max_out) begin
                    report_mismatch($sformatf("max_out %0d, predicted %0d",
                        got.max_out, want.max_out));
                end
                if (got.fill_level !== want.fill_level) begin
                    report_mismatch($sformatf("fill_level %0d, predicted %0d",
                        got.fill_level, want.fill_level));
                end
                if (got.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, predicted %0d",
                        got.status, want.status));
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    heap_scoreboard sb;

    max_heap_priority_queue_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

    // Requests and responses are taken at the edge with the values held before it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start && !busy) begin
                sb.note_request(i_req);
            end
            if (o_done) begin
                sb.check_response(o_rsp);
            end
        end
    end

    // Leaves start high after acceptance so back-to-back requests never toggle it.
    task send_req(t_req_type kind, logic signed [KEY_W-1:0] key, int gap);
        t_req rq;
        rq.req_type = kind;
        rq.key_in = key;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task wait_all_answered();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    task run_phase(int n_items, int insert_pct, bit no_idle);
        logic signed [KEY_W-1:0] key;
        t_req_type kind;
        int gap;
        for (int n = 0; n < n_items; n++) begin
            kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
            case ($urandom_range(0, 9))
                5, 6, 7: begin
                    // A narrow range makes equal keys common.
                    key = $urandom_range(0, 8);
                    key = key - 4;
                end
                8: key = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                9: key = $urandom_range(0, 1) ? 32'sh7FFF_FFF0 + $urandom_range(0, 15)
                                              : 32'sh8000_0000 + $urandom_range(0, 15);
                default: key = $urandom;
            endcase
            gap = no_idle ? 0 : $urandom_range(0, 14);
            send_req(kind, key, gap);
        end
        wait_all_answered();
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty refusal, extreme and equal keys, drain to empty and beyond.
        send_req(REQ_REMOVE, 32'sh0, 0);
        send_req(REQ_INSERT, 32'sh7FFF_FFFF, 0);
        send_req(REQ_INSERT, 32'sh8000_0000, 3);
        send_req(REQ_INSERT, 32'sh0, 0);
        send_req(REQ_INSERT, -32'sd1, 1);
        send_req(REQ_INSERT, 32'sd1, 0);
        send_req(REQ_INSERT, 32'sd5, 0);
        send_req(REQ_INSERT, 32'sd5, 7);
        send_req(REQ_INSERT, 32'sd5, 0);
        send_req(REQ_REMOVE, 32'sh7FFF_FFFF, 0);
        for (int n = 0; n < 7; n++) begin
            send_req(REQ_REMOVE, 32'sh0, n % 3);
        end
        send_req(REQ_REMOVE, -32'sd1, 0);
        send_req(REQ_INSERT, 32'sh8000_0000, 2);
        send_req(REQ_REMOVE, 32'sh0, 0);
        wait_all_answered();

        // Each round fills past full, drains past empty, then mixes.
        for (int r = 0; r < 4; r++) begin
            run_phase(80, 95, r == 1);
            run_phase(80, 5, r == 2);
            run_phase(50, 50, r == 3);
        end

        wait_all_answered();
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/mhpq_pkg.sv
design/mhpq_ram.sv
design/max_heap_priority_queue_core.sv
verif/max_heap_priority_queue_core_tb.sv
